// ===== hw/rtl/pcc_pkg.sv =====
// Shared types and constants of the 2D penalty contact block.
package pcc_pkg;

   localparam int FRACTION_BITS = 16;

   typedef enum logic [1:0] {
      OP_EVAL_FULL  = 2'd0,
      OP_EVAL_FORCE = 2'd1,
      OP_COMMIT     = 2'd2,
      OP_REVERT     = 2'd3
   } op_type;

   localparam logic [1:0] CS_NONE  = 2'd0;
   localparam logic [1:0] CS_STICK = 2'd1;
   localparam logic [1:0] CS_SLIDE = 2'd2;

   localparam logic [2:0] REG_NORMAL_X          = 3'd0;
   localparam logic [2:0] REG_NORMAL_Y          = 3'd1;
   localparam logic [2:0] REG_NORMAL_STIFFNESS  = 3'd2;
   localparam logic [2:0] REG_TANGENT_STIFFNESS = 3'd3;
   localparam logic [2:0] REG_FRICTION_RATIO    = 3'd4;
   localparam logic [2:0] REG_COORD_OFFSET_X    = 3'd5;
   localparam logic [2:0] REG_COORD_OFFSET_Y    = 3'd6;
   localparam logic [2:0] REG_ELEMENT_SCALE     = 3'd7;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] slave_disp_x;
      logic signed [31:0] slave_disp_y;
      logic signed [31:0] master_disp_x;
      logic signed [31:0] master_disp_y;
   } req_type;

   typedef struct packed {
      logic [1:0]         row;
      logic               last;
      logic [1:0]         contact_state;
      logic signed [63:0] force_res;
      logic signed [63:0] stiff_col0;
      logic signed [63:0] stiff_col1;
      logic signed [63:0] stiff_col2;
      logic signed [63:0] stiff_col3;
      logic signed [31:0] gap_value;
      logic [62:0]        contact_pressure;
   } rsp_type;

   typedef struct packed {
      logic signed [17:0] normal_x;
      logic signed [17:0] normal_y;
      logic [47:0]        normal_stiffness;
      logic [47:0]        tangent_stiffness;
      logic [19:0]        friction_ratio;
      logic signed [31:0] coord_offset_x;
      logic signed [31:0] coord_offset_y;
      logic [16:0]        element_scale;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
   } qent_type;

endpackage

// ===== hw/rtl/pcc_front.sv =====
// Front end: accept requests, decode the mode and form the relative offsets.
module pcc_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  pcc_pkg::req_type   req_data,
   input  pcc_pkg::cfg_type   cfg,
   input  logic               q_full,
   output logic               q_push,
   output pcc_pkg::qent_type  q_data
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data.op = pcc_pkg::op_type'(req_data.mode);
      q_data.sx = req_data.slave_disp_x;
      q_data.sy = req_data.slave_disp_y;
      q_data.mx = req_data.master_disp_x;
      q_data.my = req_data.master_disp_y;
      q_data.dx = {{2{cfg.coord_offset_x[31]}}, cfg.coord_offset_x}
                + {{2{req_data.master_disp_x[31]}}, req_data.master_disp_x}
                - {{2{req_data.slave_disp_x[31]}}, req_data.slave_disp_x};
      q_data.dy = {{2{cfg.coord_offset_y[31]}}, cfg.coord_offset_y}
                + {{2{req_data.master_disp_y[31]}}, req_data.master_disp_y}
                - {{2{req_data.slave_disp_y[31]}}, req_data.slave_disp_y};
   end

endmodule

// ===== hw/rtl/pcc_fifo.sv =====
// Two-entry queue between the front end and the compute engine.
module pcc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff         <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== hw/rtl/pcc_qmul.sv =====
// Shared fixed-point multiplier: 64x16 per cycle, truncate toward zero, saturate.
module pcc_qmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] result
);

   logic [63:0]        xa_ff;
   logic [63:0]        yb_ff;
   logic               neg_ff;
   logic [127:0]       acc_ff;
   logic [1:0]         cnt_ff;
   logic               run_ff;
   logic               fin_ff;
   logic               done_ff;
   logic signed [63:0] result_ff;

   logic [79:0]        prod;
   logic [127:0]       acc_in;
   logic [127:0]       shifted;
   logic [63:0]        lim;
   logic [63:0]        mag_sat;
   logic signed [63:0] result_in;

   assign prod    = xa_ff * {64'd0, yb_ff[15:0]};
   assign acc_in  = {16'd0, acc_ff[127:16]} + {prod, 48'd0};
   assign shifted = acc_ff >> pcc_pkg::FRACTION_BITS;
   assign lim     = neg_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
   assign mag_sat = (shifted > {64'd0, lim}) ? lim : shifted[63:0];
   assign result_in = neg_ff ? -$signed(mag_sat) : $signed(mag_sat);

   assign done   = done_ff;
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (fin_ff) begin
            result_ff <= result_in;
         end
         if (start) begin
            xa_ff  <= a[63] ? 64'd0 - a : a;
            yb_ff  <= b[63] ? 64'd0 - b : b;
            neg_ff <= a[63] ^ b[63];
            acc_ff <= 128'd0;
            cnt_ff <= 2'd0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            acc_ff <= acc_in;
            yb_ff  <= yb_ff >> 16;
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/pcc_back.sv =====
// Compute engine: gap, slip, stick/slide decision and the four result rows.
module pcc_back (
   input  logic               clock,
   input  logic               reset,
   input  pcc_pkg::cfg_type   cfg,
   input  logic               q_empty,
   input  pcc_pkg::qent_type  q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pcc_pkg::rsp_type   rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAL   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_RES    = 6'b001000,
      ST_STF    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type          state_ff;
   pcc_pkg::op_type    mode_ff;
   logic signed [31:0] u_ff [4];
   logic signed [33:0] dx_ff;
   logic signed [33:0] dy_ff;
   logic [3:0]         uop_ff;
   logic [2:0]         sub_ff;
   logic [1:0]         col_ff;
   logic [1:0]         row_ff;
   logic               qbusy_ff;

   logic signed [55:0] accs_ff;
   logic signed [31:0] gap_ff;
   logic signed [31:0] slip_ff;
   logic signed [31:0] trial_ff;
   logic signed [31:0] stick_ff;
   logic [1:0]         lastcs_ff;
   logic [1:0]         cs_ff;
   logic signed [63:0] pres_ff;
   logic signed [63:0] t_ff;
   logic signed [63:0] lim_ff;
   logic signed [63:0] coefs_ff;
   logic signed [63:0] shear_ff;
   logic signed [63:0] coef_ff;
   logic signed [63:0] r1_ff;
   logic signed [63:0] r2_ff;
   logic signed [63:0] res_ff;
   logic signed [39:0] nn_ff;
   logic signed [39:0] oth_ff;
   logic signed [63:0] k1_ff;
   logic signed [63:0] k2_ff;
   logic signed [63:0] stf_ff [4];
   logic               rsp_valid_ff;
   pcc_pkg::rsp_type   rsp_data_ff;

   logic signed [18:0] nv [4];
   logic signed [18:0] nvneg [4];
   logic signed [18:0] tv [4];
   logic signed [18:0] nx19;
   logic signed [18:0] ny19;

   logic signed [34:0] sa;
   logic signed [18:0] sb;
   logic               sclear;
   logic signed [53:0] sprod;
   logic signed [55:0] accsum;
   logic signed [55:0] sfloor;
   logic signed [31:0] sat_in;
   logic [1:0]         kidx;

   logic               is_q;
   logic               qstart;
   logic signed [63:0] qa;
   logic signed [63:0] qb;
   logic               qdone;
   logic signed [63:0] qres;

   logic signed [32:0] slip_rel;
   logic [63:0]        tmag;
   logic               out_free;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      logic signed [64:0] s;
      s = {x[63], x} + {y[63], y};
      if (s[64] != s[63]) begin
         sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add = s[63:0];
      end
   endfunction

   assign nx19 = {cfg.normal_x[17], cfg.normal_x};
   assign ny19 = {cfg.normal_y[17], cfg.normal_y};
   assign nv[0] = nx19;
   assign nv[1] = ny19;
   assign nv[2] = -nx19;
   assign nv[3] = -ny19;
   assign nvneg[0] = -nx19;
   assign nvneg[1] = -ny19;
   assign nvneg[2] = nx19;
   assign nvneg[3] = ny19;
   assign tv[0] = ny19;
   assign tv[1] = -nx19;
   assign tv[2] = -ny19;
   assign tv[3] = nx19;

   assign kidx = uop_ff[1:0] - 2'd2;

   always_comb begin
      sa     = '0;
      sb     = '0;
      sclear = 1'b1;
      case (state_ff)
         ST_SCAL: begin
            if (uop_ff == 4'd0) begin
               sa = {dx_ff[33], dx_ff};
               sb = nx19;
            end else if (uop_ff == 4'd1) begin
               sa     = {dy_ff[33], dy_ff};
               sb     = ny19;
               sclear = 1'b0;
            end else begin
               sa     = {{3{u_ff[kidx][31]}}, u_ff[kidx]};
               sb     = tv[kidx];
               sclear = (uop_ff == 4'd2);
            end
         end
         ST_STF: begin
            if (sub_ff == 3'd0) begin
               sa = {{16{nv[row_ff][18]}}, nv[row_ff]};
               sb = nv[col_ff];
            end else begin
               sa = {{16{tv[row_ff][18]}}, tv[row_ff]};
               sb = (cs_ff == pcc_pkg::CS_STICK) ? tv[col_ff] : nv[col_ff];
            end
         end
         default: begin
            sa = '0;
         end
      endcase
   end

   assign sprod  = sa * sb;
   assign accsum = (sclear ? 56'sd0 : accs_ff) + 56'(sprod);
   assign sfloor = accsum >>> pcc_pkg::FRACTION_BITS;

   always_comb begin
      if (sfloor > 56'sd2147483647) begin
         sat_in = 32'sh7fffffff;
      end else if (sfloor < -56'sd2147483648) begin
         sat_in = 32'sh80000000;
      end else begin
         sat_in = sfloor[31:0];
      end
   end

   assign is_q = ((state_ff == ST_SCAL) && (uop_ff >= 4'd6)) || (state_ff == ST_RES)
              || ((state_ff == ST_STF) && (sub_ff == 3'd1 || sub_ff == 3'd3 || sub_ff == 3'd4));
   assign qstart = is_q && !qbusy_ff;

   assign slip_rel = {slip_ff[31], slip_ff} - {stick_ff[31], stick_ff};

   always_comb begin
      qa = '0;
      qb = '0;
      case (state_ff)
         ST_SCAL: begin
            case (uop_ff)
               4'd6: begin
                  qa = {16'd0, cfg.normal_stiffness};
                  qb = {{32{gap_ff[31]}}, gap_ff};
               end
               4'd7: begin
                  qa = {16'd0, cfg.tangent_stiffness};
                  qb = {{31{slip_rel[32]}}, slip_rel};
               end
               4'd8: begin
                  qa = {44'd0, cfg.friction_ratio};
                  qb = pres_ff;
               end
               default: begin
                  qa = {44'd0, cfg.friction_ratio};
                  qb = {16'd0, cfg.normal_stiffness};
               end
            endcase
         end
         ST_RES: begin
            case (sub_ff)
               3'd0: begin
                  qa = pres_ff;
                  qb = {{45{nvneg[row_ff][18]}}, nvneg[row_ff]};
               end
               3'd1: begin
                  qa = shear_ff;
                  qb = {{45{tv[row_ff][18]}}, tv[row_ff]};
               end
               default: begin
                  qa = sat_add(r1_ff, r2_ff);
                  qb = {47'd0, cfg.element_scale};
               end
            endcase
         end
         ST_STF: begin
            case (sub_ff)
               3'd1: begin
                  qa = {16'd0, cfg.normal_stiffness};
                  qb = {{24{nn_ff[39]}}, nn_ff};
               end
               3'd3: begin
                  qa = coef_ff;
                  qb = {{24{oth_ff[39]}}, oth_ff};
               end
               default: begin
                  qa = sat_add(k1_ff, k2_ff);
                  qb = {47'd0, cfg.element_scale};
               end
            endcase
         end
         default: begin
            qa = '0;
         end
      endcase
   end

   pcc_qmul u_qmul (
      .clock  (clock),
      .reset  (reset),
      .start  (qstart),
      .a      (qa),
      .b      (qb),
      .done   (qdone),
      .result (qres)
   );

   assign tmag     = t_ff[63] ? 64'd0 - t_ff : t_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qbusy_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stick_ff     <= '0;
         trial_ff     <= '0;
         lastcs_ff    <= pcc_pkg::CS_NONE;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (qstart) begin
            qbusy_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  case (q_data.op)
                     pcc_pkg::OP_COMMIT: begin
                        if (lastcs_ff == pcc_pkg::CS_SLIDE) begin
                           stick_ff <= trial_ff;
                        end
                     end
                     pcc_pkg::OP_REVERT: begin
                        stick_ff <= '0;
                     end
                     default: begin
                        mode_ff  <= q_data.op;
                        u_ff[0]  <= q_data.sx;
                        u_ff[1]  <= q_data.sy;
                        u_ff[2]  <= q_data.mx;
                        u_ff[3]  <= q_data.my;
                        dx_ff    <= q_data.dx;
                        dy_ff    <= q_data.dy;
                        uop_ff   <= 4'd0;
                        state_ff <= ST_SCAL;
                     end
                  endcase
               end
            end
            ST_SCAL: begin
               if (uop_ff == 4'd2 && gap_ff[31]) begin
                  pres_ff   <= '0;
                  res_ff    <= '0;
                  stf_ff[0] <= '0;
                  stf_ff[1] <= '0;
                  stf_ff[2] <= '0;
                  stf_ff[3] <= '0;
                  cs_ff     <= pcc_pkg::CS_NONE;
                  lastcs_ff <= pcc_pkg::CS_NONE;
                  row_ff    <= 2'd0;
                  state_ff  <= ST_EMIT;
               end else if (uop_ff <= 4'd5) begin
                  accs_ff <= accsum;
                  if (uop_ff == 4'd1) begin
                     gap_ff <= sat_in;
                  end
                  if (uop_ff == 4'd5) begin
                     slip_ff  <= sat_in;
                     trial_ff <= sat_in;
                  end
                  uop_ff <= uop_ff + 4'd1;
               end else if (qdone) begin
                  qbusy_ff <= 1'b0;
                  case (uop_ff)
                     4'd6:    pres_ff  <= qres;
                     4'd7:    t_ff     <= qres;
                     4'd8:    lim_ff   <= qres;
                     default: coefs_ff <= qres;
                  endcase
                  if (uop_ff == 4'd9) begin
                     state_ff <= ST_DECIDE;
                  end else begin
                     uop_ff <= uop_ff + 4'd1;
                  end
               end
            end
            ST_DECIDE: begin
               if (tmag <= lim_ff) begin
                  cs_ff     <= pcc_pkg::CS_STICK;
                  lastcs_ff <= pcc_pkg::CS_STICK;
                  shear_ff  <= t_ff;
                  coef_ff   <= {16'd0, cfg.tangent_stiffness};
               end else begin
                  cs_ff     <= pcc_pkg::CS_SLIDE;
                  lastcs_ff <= pcc_pkg::CS_SLIDE;
                  shear_ff  <= t_ff[63] ? -lim_ff : lim_ff;
                  coef_ff   <= t_ff[63] ? coefs_ff : -coefs_ff;
               end
               stf_ff[0] <= '0;
               stf_ff[1] <= '0;
               stf_ff[2] <= '0;
               stf_ff[3] <= '0;
               row_ff    <= 2'd0;
               sub_ff    <= 3'd0;
               state_ff  <= ST_RES;
            end
            ST_RES: begin
               if (qdone) begin
                  qbusy_ff <= 1'b0;
                  case (sub_ff)
                     3'd0:    r1_ff  <= qres;
                     3'd1:    r2_ff  <= qres;
                     default: res_ff <= qres;
                  endcase
                  if (sub_ff == 3'd2) begin
                     sub_ff <= 3'd0;
                     col_ff <= 2'd0;
                     if (mode_ff == pcc_pkg::OP_EVAL_FORCE) begin
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_STF;
                     end
                  end else begin
                     sub_ff <= sub_ff + 3'd1;
                  end
               end
            end
            ST_STF: begin
               if (sub_ff == 3'd0 || sub_ff == 3'd2) begin
                  if (sub_ff == 3'd0) begin
                     nn_ff <= sfloor[39:0];
                  end else begin
                     oth_ff <= sfloor[39:0];
                  end
                  sub_ff <= sub_ff + 3'd1;
               end else if (qdone) begin
                  qbusy_ff <= 1'b0;
                  case (sub_ff)
                     3'd1:    k1_ff          <= qres;
                     3'd3:    k2_ff          <= qres;
                     default: stf_ff[col_ff] <= qres;
                  endcase
                  if (sub_ff == 3'd4) begin
                     sub_ff <= 3'd0;
                     if (col_ff == 2'd3) begin
                        state_ff <= ST_EMIT;
                     end else begin
                        col_ff <= col_ff + 2'd1;
                     end
                  end else begin
                     sub_ff <= sub_ff + 3'd1;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff                  <= 1'b1;
                  rsp_data_ff.row               <= row_ff;
                  rsp_data_ff.last              <= (row_ff == 2'd3);
                  rsp_data_ff.contact_state     <= cs_ff;
                  rsp_data_ff.force_res         <= res_ff;
                  rsp_data_ff.stiff_col0        <= stf_ff[0];
                  rsp_data_ff.stiff_col1        <= stf_ff[1];
                  rsp_data_ff.stiff_col2        <= stf_ff[2];
                  rsp_data_ff.stiff_col3        <= stf_ff[3];
                  rsp_data_ff.gap_value         <= gap_ff;
                  rsp_data_ff.contact_pressure  <= pres_ff[62:0];
                  if (row_ff == 2'd3) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff <= row_ff + 2'd1;
                     sub_ff <= 3'd0;
                     if (cs_ff != pcc_pkg::CS_NONE) begin
                        state_ff <= ST_RES;
                     end
                  end
               end else if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/penalty_contact_coulomb_friction_2d_core.sv =====
// Top level of the 2D penalty contact element with Coulomb friction.
// A request is decoded and queued (two entries) by the front end; the compute
// engine then works one request at a time through a single shared multiplier
// that takes 64x16 bits per cycle.
// Commit and revert give no result. An evaluation outside contact gives its four
// rows without a product on the multiplier; in contact the time of a force-only
// evaluation, and more so of a full evaluation with the stiffness rows, is set
// by the number of products on that multiplier.
// A finished row sits in the output register while the next one is computed,
// and new requests are queued while the engine is busy.
module penalty_contact_coulomb_friction_2d_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcc_pkg::rsp_type  rsp_data,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [47:0]       csr_wdata
);

   pcc_pkg::cfg_type  cfg_ff;
   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   pcc_pkg::qent_type q_in;
   pcc_pkg::qent_type q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_x          <= '0;
         cfg_ff.normal_y          <= 18'(1) << pcc_pkg::FRACTION_BITS;
         cfg_ff.normal_stiffness  <= '0;
         cfg_ff.tangent_stiffness <= '0;
         cfg_ff.friction_ratio    <= '0;
         cfg_ff.coord_offset_x    <= '0;
         cfg_ff.coord_offset_y    <= '0;
         cfg_ff.element_scale     <= 17'(1) << pcc_pkg::FRACTION_BITS;
      end else if (csr_write_en) begin
         case (csr_index)
            pcc_pkg::REG_NORMAL_X:          cfg_ff.normal_x          <= csr_wdata[17:0];
            pcc_pkg::REG_NORMAL_Y:          cfg_ff.normal_y          <= csr_wdata[17:0];
            pcc_pkg::REG_NORMAL_STIFFNESS:  cfg_ff.normal_stiffness  <= csr_wdata;
            pcc_pkg::REG_TANGENT_STIFFNESS: cfg_ff.tangent_stiffness <= csr_wdata;
            pcc_pkg::REG_FRICTION_RATIO:    cfg_ff.friction_ratio    <= csr_wdata[19:0];
            pcc_pkg::REG_COORD_OFFSET_X:    cfg_ff.coord_offset_x    <= csr_wdata[31:0];
            pcc_pkg::REG_COORD_OFFSET_Y:    cfg_ff.coord_offset_y    <= csr_wdata[31:0];
            pcc_pkg::REG_ELEMENT_SCALE:     cfg_ff.element_scale     <= csr_wdata[16:0];
            default: cfg_ff.element_scale <= cfg_ff.element_scale;
         endcase
      end
   end

   pcc_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   pcc_fifo #(
      .WIDTH($bits(pcc_pkg::qent_type))
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   pcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_penalty_contact_coulomb_friction_2d_core.sv =====
// Testbench for the 2D penalty contact core with a built-in row predictor.
module tb_penalty_contact_coulomb_friction_2d_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = pcc_pkg::FRACTION_BITS;
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pcc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pcc_pkg::rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_wdata = '0;

   penalty_contact_coulomb_friction_2d_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // contact model state
   longint nx_r, ny_r, kn_r, kt_r, mu_r, ox_r, oy_r, scale_r;
   longint stick_pt, slip_last;
   logic [1:0] prev_state;

   pcc_pkg::rsp_type expected_rows[$];
   int mismatches = 0;
   int cycles = 0;
   bit calm = 1'b0;

   function automatic longint flr(longint v);
      return v >>> FB;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      logic signed [129:0] p;
      logic signed [129:0] q;
      p = 130'(signed'(a)) * 130'(signed'(b));
      q = (p < 0) ? -((-p) >>> FB) : (p >>> FB);
      if (q > 130'(I64_MAX)) return I64_MAX;
      if (q < 130'(I64_MIN)) return I64_MIN;
      return longint'(q);
   endfunction

   function automatic longint sat_add(longint a, longint b);
      logic signed [65:0] s;
      s = 66'(a) + 66'(b);
      if (s > 66'(I64_MAX)) return I64_MAX;
      if (s < 66'(I64_MIN)) return I64_MIN;
      return longint'(s);
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic predict_contact(input pcc_pkg::req_type r);
      longint sx, sy, mx, my, gap, pres, shear, coef, slip, t, lim, nn, other, k;
      longint nv[4], tv[4], u[4], res[4];
      longint stf[4][4];
      logic [1:0] cs;
      pcc_pkg::rsp_type e;
      if (r.mode == pcc_pkg::OP_COMMIT) begin
         if (prev_state == pcc_pkg::CS_SLIDE) stick_pt = slip_last;
         return;
      end
      if (r.mode == pcc_pkg::OP_REVERT) begin
         stick_pt = 0;
         return;
      end
      sx = r.slave_disp_x; sy = r.slave_disp_y;
      mx = r.master_disp_x; my = r.master_disp_y;
      gap = sat32(flr((ox_r + mx - sx) * nx_r + (oy_r + my - sy) * ny_r));
      nv = '{nx_r, ny_r, -nx_r, -ny_r};
      tv = '{ny_r, -nx_r, -ny_r, nx_r};
      u = '{sx, sy, mx, my};
      res = '{0, 0, 0, 0};
      stf = '{default: 0};
      pres = 0;
      cs = pcc_pkg::CS_NONE;
      if (gap >= 0) begin
         slip = 0;
         for (int i = 0; i < 4; i++) slip += tv[i] * u[i];
         slip = sat32(flr(slip));
         slip_last = slip;
         pres = fx_mul(kn_r, gap);
         t = fx_mul(kt_r, slip - stick_pt);
         lim = fx_mul(mu_r, pres);
         if (t != I64_MIN && mag(t) <= lim) begin
            cs = pcc_pkg::CS_STICK;
            shear = t;
         end else begin
            cs = pcc_pkg::CS_SLIDE;
            shear = (t < 0) ? -lim : lim;
         end
         coef = (cs == pcc_pkg::CS_STICK) ? kt_r : fx_mul(mu_r, kn_r);
         if (cs == pcc_pkg::CS_SLIDE && t > 0) coef = -coef;
         for (int i = 0; i < 4; i++) begin
            res[i] = fx_mul(sat_add(fx_mul(pres, -nv[i]), fx_mul(shear, tv[i])), scale_r);
            if (r.mode == pcc_pkg::OP_EVAL_FULL) begin
               for (int j = 0; j < 4; j++) begin
                  nn = flr(nv[i] * nv[j]);
                  other = (cs == pcc_pkg::CS_STICK) ? tv[i] * tv[j] : tv[i] * nv[j];
                  k = sat_add(fx_mul(kn_r, nn), fx_mul(coef, flr(other)));
                  stf[i][j] = fx_mul(k, scale_r);
               end
            end
         end
      end
      prev_state = cs;
      for (int i = 0; i < 4; i++) begin
         e.row = 2'(i);
         e.last = (i == 3);
         e.contact_state = cs;
         e.force_res = res[i];
         e.stiff_col0 = stf[i][0];
         e.stiff_col1 = stf[i][1];
         e.stiff_col2 = stf[i][2];
         e.stiff_col3 = stf[i][3];
         e.gap_value = 32'(gap);
         e.contact_pressure = 63'(pres);
         expected_rows.push_back(e);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         pcc_pkg::REG_NORMAL_X: nx_r = longint'(signed'(val[17:0]));
         pcc_pkg::REG_NORMAL_Y: ny_r = longint'(signed'(val[17:0]));
         pcc_pkg::REG_NORMAL_STIFFNESS: kn_r = longint'({16'd0, val});
         pcc_pkg::REG_TANGENT_STIFFNESS: kt_r = longint'({16'd0, val});
         pcc_pkg::REG_FRICTION_RATIO: mu_r = longint'(val[19:0]);
         pcc_pkg::REG_COORD_OFFSET_X: ox_r = longint'(signed'(val[31:0]));
         pcc_pkg::REG_COORD_OFFSET_Y: oy_r = longint'(signed'(val[31:0]));
         default: scale_r = longint'(val[16:0]);
      endcase
   endtask

   task automatic send_req(input pcc_pkg::op_type op, input longint sx, input longint sy,
                           input longint mx, input longint my);
      pcc_pkg::req_type r;
      r.mode = op;
      r.slave_disp_x = 32'(sx); r.slave_disp_y = 32'(sy);
      r.master_disp_x = 32'(mx); r.master_disp_y = 32'(my);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_contact(r);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_contact(input longint nx, input longint ny, input longint kn,
                              input longint kt, input longint mu, input longint ox,
                              input longint oy, input longint sc);
      drain();
      write_reg(pcc_pkg::REG_NORMAL_X, 48'(nx));
      write_reg(pcc_pkg::REG_NORMAL_Y, 48'(ny));
      write_reg(pcc_pkg::REG_NORMAL_STIFFNESS, 48'(kn));
      write_reg(pcc_pkg::REG_TANGENT_STIFFNESS, 48'(kt));
      write_reg(pcc_pkg::REG_FRICTION_RATIO, 48'(mu));
      write_reg(pcc_pkg::REG_COORD_OFFSET_X, 48'(ox));
      write_reg(pcc_pkg::REG_COORD_OFFSET_Y, 48'(oy));
      write_reg(pcc_pkg::REG_ELEMENT_SCALE, 48'(sc));
      csr_write_en <= 1'b0;
   endtask

   function automatic longint rnd32();
      return longint'(signed'($urandom()));
   endfunction

   function automatic longint small_disp();
      return longint'($urandom_range(0, 262144)) - 131072;
   endfunction

   task automatic test_reset_defaults;
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 0, 0);
      send_req(pcc_pkg::OP_EVAL_FORCE, 0, 65536, 0, 0);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 0, 65536);
   endtask

   task automatic test_stick_slide_commit;
      set_contact(0, 65536, 100 << 16, 50 << 16, 19661, 0, 0, 65536);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 0, 65536);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 2 << 16, 65536);
      send_req(pcc_pkg::OP_COMMIT, 0, 0, 0, 0);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 2 << 16, 65536);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, -(3 << 16), 65536);
      send_req(pcc_pkg::OP_COMMIT, 0, 0, 0, 0);
      send_req(pcc_pkg::OP_REVERT, 0, 0, 0, 0);
      send_req(pcc_pkg::OP_EVAL_FORCE, 0, 0, 1 << 16, 65536);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 65536, 0, 0);
      send_req(pcc_pkg::OP_COMMIT, 0, 0, 0, 0);
      set_contact(0, 65536, 0, 0, 0, 0, 0, 65536);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 0, 0);
   endtask

   task automatic test_extremes;
      set_contact(-131072, 131071, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 20'hFFFFF,
                  -2147483648, 2147483647, 131071);
      send_req(pcc_pkg::OP_EVAL_FULL, -2147483648, 2147483647, 2147483647, -2147483648);
      send_req(pcc_pkg::OP_EVAL_FULL, 2147483647, -2147483648, -2147483648, 2147483647);
      send_req(pcc_pkg::OP_EVAL_FORCE, -1, -1, -1, -1);
      set_contact(65536, -65536, 48'hFFFF_FFFF_FFFF, 1, 1, 2147483647, -2147483648, 0);
      send_req(pcc_pkg::OP_EVAL_FULL, -2147483648, 2147483647, 2147483647, -2147483648);
      send_req(pcc_pkg::OP_EVAL_FULL, 0, 0, 0, 0);
   endtask

   task automatic test_random(input int n, input bit wide);
      int op;
      for (int i = 0; i < n; i++) begin
         op = $urandom_range(0, 9);
         if (op < 4)
            send_req(pcc_pkg::OP_EVAL_FULL, small_disp(), small_disp(), small_disp(),
                     small_disp());
         else if (op < 7)
            send_req(pcc_pkg::OP_EVAL_FORCE, wide ? rnd32() : small_disp(), small_disp(),
                     small_disp(), wide ? rnd32() : small_disp());
         else if (op < 9)
            send_req(pcc_pkg::OP_COMMIT, rnd32(), rnd32(), rnd32(), rnd32());
         else
            send_req(pcc_pkg::OP_REVERT, rnd32(), rnd32(), rnd32(), rnd32());
      end
   endtask

   task automatic test_random_configs;
      for (int c = 0; c < 4; c++) begin
         set_contact(longint'($urandom_range(0, 131072)) - 65536,
                     longint'($urandom_range(0, 131072)) - 65536,
                     longint'($urandom_range(0, 1 << 24)) << $urandom_range(0, 8),
                     longint'($urandom_range(0, 1 << 24)) << $urandom_range(0, 8),
                     $urandom_range(0, 1048575), small_disp(), small_disp(),
                     $urandom_range(0, 65536));
         test_random(20, c == 3);
      end
      calm = 1'b1;
      test_random(15, 1'b0);
   endtask

   // response side: random stalls, compare each transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (calm) rsp_ready <= 1'b1;
         else if ($urandom_range(0, 4) == 0) rsp_ready <= ~rsp_ready;
         else if (!rsp_ready && $urandom_range(0, 2) == 0) rsp_ready <= 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            pcc_pkg::rsp_type e;
            e = expected_rows.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch\n exp %p\n got %p", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      nx_r = 0; ny_r = 65536; kn_r = 0; kt_r = 0; mu_r = 0; ox_r = 0; oy_r = 0;
      scale_r = 65536; stick_pt = 0; slip_last = 0; prev_state = pcc_pkg::CS_NONE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_stick_slide_commit();
      test_extremes();
      test_random_configs();
      drain();
      if (mismatches == 0 && expected_rows.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
